@@ rtl/tsh_pkg.sv @@
// Shared types and constants for the trimmed statistics histogram unit.
package tsh_pkg;

    localparam int NUM_BINS = 21;
    localparam int BIN_W = 5;
    localparam int GRADE_MAX = 100;

    localparam logic [1:0] KIND_STATUS  = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_BIN     = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RANGE    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_TOO_FEW  = 2'd3;

    // Classified command passed from the front end to the back end.
    typedef enum logic [1:0]
    {
        CMD_ADD,
        CMD_REJECT,
        CMD_END
    } cmd_t;

    typedef struct packed
    {
        cmd_t       cmd;
        logic [1:0] status;
        logic [6:0] grade;
        logic [4:0] bin;
    } front_item_t;

    typedef enum logic [3:0]
    {
        BS_IDLE,
        BS_MUL,
        BS_DIFF,
        BS_DIV_MEAN,
        BS_SQRT,
        BS_DIV_SD,
        BS_SUMMARY,
        BS_BINS,
        BS_STATUS
    } back_state_t;

    // Grade to bin index, exact for 0..100: the grade times 205/1024 floors to grade/5.
    function automatic logic [4:0] grade_bin(input logic [6:0] g);
        logic [14:0] p;
        begin
            p = {8'd0, g} * 15'd205;
            grade_bin = p[14:10];
        end
    endfunction

endpackage

@@ rtl/tsh_front.sv @@
// Front end: accepts items, checks range and capacity, and queues commands.
module tsh_front #(
    parameter int MAX_SAMPLES = 128
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid,
    output logic                 stall,
    input  logic                 action,
    input  logic [7:0]           grade,
    output logic                 q_valid,
    input  logic                 q_pop,
    output tsh_pkg::front_item_t q_item
);
    localparam int DEPTH = 2;

    tsh_pkg::front_item_t fifo_reg [DEPTH];
    logic                 wr_ptr_reg, rd_ptr_reg;
    logic [1:0]           fill_reg;
    logic [7:0]           count_reg;
    tsh_pkg::front_item_t item_next;
    logic                 push;

    assign stall = (fill_reg == 2'(DEPTH));
    assign push = valid && !stall;
    assign q_valid = (fill_reg != 2'd0);
    assign q_item = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        item_next.grade = grade[6:0];
        item_next.bin = tsh_pkg::grade_bin(grade[6:0]);
        item_next.status = tsh_pkg::ST_OK;
        if (action)
        begin
            item_next.cmd = tsh_pkg::CMD_END;
        end
        else if (grade > 8'(tsh_pkg::GRADE_MAX))
        begin
            item_next.cmd = tsh_pkg::CMD_REJECT;
            item_next.status = tsh_pkg::ST_RANGE;
        end
        else if (count_reg >= 8'(MAX_SAMPLES))
        begin
            item_next.cmd = tsh_pkg::CMD_REJECT;
            item_next.status = tsh_pkg::ST_FULL;
        end
        else
        begin
            item_next.cmd = tsh_pkg::CMD_ADD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg <= 2'd0;
            count_reg <= 8'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
                if (item_next.cmd == tsh_pkg::CMD_END)
                begin
                    count_reg <= 8'd0;
                end
                else if (item_next.cmd == tsh_pkg::CMD_ADD)
                begin
                    count_reg <= count_reg + 8'd1;
                end
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= item_next;
        end
    end
endmodule

@@ rtl/tsh_divider.sv @@
// Shared restoring divider, one quotient bit per cycle.
module tsh_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [7:0]  divisor,
    output logic        done,
    output logic [31:0] quotient
);
    logic [31:0] quo_reg;
    logic [8:0]  rem_reg;
    logic [7:0]  dvs_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [8:0]  trial;
    logic [8:0]  sub;

    assign trial = {rem_reg[7:0], quo_reg[31]};
    assign sub = trial - {1'b0, dvs_reg};
    assign quotient = quo_reg;
    assign done = busy_reg && (cnt_reg == 6'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= 6'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg <= 6'd32;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= 9'd0;
            dvs_reg <= divisor;
        end
        else if (busy_reg && cnt_reg != 6'd0)
        begin
            if (!sub[8])
            begin
                rem_reg <= sub;
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end
endmodule

@@ rtl/tsh_sqrt.sv @@
// Floor integer square root, one result bit per cycle.
module tsh_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] radicand,
    output logic        done,
    output logic [23:0] root
);
    logic [47:0] rad_reg;
    logic [23:0] root_reg;
    logic [25:0] rem_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic [25:0] trial;
    logic [25:0] cand;

    assign trial = {rem_reg[23:0], rad_reg[47:46]};
    assign cand = {root_reg, 2'b01};
    assign root = root_reg;
    assign done = busy_reg && (cnt_reg == 5'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= 5'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg <= 5'd24;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg <= radicand;
            root_reg <= 24'd0;
            rem_reg <= 26'd0;
        end
        else if (busy_reg && cnt_reg != 5'd0)
        begin
            rad_reg <= {rad_reg[45:0], 2'b00};
            if (trial >= cand)
            begin
                rem_reg <= trial - cand;
                root_reg <= {root_reg[22:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                root_reg <= {root_reg[22:0], 1'b0};
            end
        end
    end
endmodule

@@ rtl/tsh_back.sv @@
// Back end: accumulates statistics and produces status, summary and bin results.
module tsh_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  tsh_pkg::front_item_t q_item,
    output logic                 valid,
    input  logic                 stall,
    output logic [1:0]           kind,
    output logic [1:0]           status,
    output logic [6:0]           removed_min,
    output logic [6:0]           removed_max,
    output logic [14:0]          mean_value,
    output logic [13:0]          std_dev,
    output logic [4:0]           bin_index,
    output logic [7:0]           bin_count,
    output logic                 last
);
    tsh_pkg::back_state_t state_reg, state_next;

    logic [7:0]  count_reg;
    logic [13:0] sum_reg;
    logic [20:0] sumsq_reg;
    logic [6:0]  lo_reg, hi_reg;
    logic [7:0]  bins_reg [tsh_pkg::NUM_BINS];
    logic [4:0]  bidx_reg;

    // Trimmed quantities and pipeline registers for the end computation.
    logic [7:0]  m_reg;
    logic [13:0] s_reg;
    logic [20:0] q_reg;
    logic [28:0] mq_reg;
    logic [27:0] ss_reg;
    logic [28:0] d_reg;
    logic [14:0] mean_reg;
    logic [13:0] sd_reg;

    // Output register.
    logic        ovalid_reg;
    logic [1:0]  kind_reg, status_reg;
    logic [6:0]  rmin_reg, rmax_reg;
    logic [14:0] omean_reg;
    logic [13:0] osd_reg;
    logic [4:0]  obidx_reg;
    logic [7:0]  obcnt_reg;
    logic        last_reg;

    logic        out_free;
    logic        out_load;
    logic        div_start, sqrt_start, div_done, sqrt_done;
    logic [31:0] div_dividend, div_quo;
    logic [23:0] root;
    logic        is_mean_reg;
    logic [13:0] g_sq;

    assign out_free = !ovalid_reg || !stall;
    assign g_sq = {7'd0, q_item.grade} * {7'd0, q_item.grade};

    tsh_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (m_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    tsh_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand ({3'd0, d_reg, 16'd0}),
        .done     (sqrt_done),
        .root     (root)
    );

    assign div_dividend = is_mean_reg ? {10'd0, s_reg, 8'd0} : {8'd0, root};

    always_comb
    begin
        state_next = state_reg;
        q_pop = 1'b0;
        out_load = 1'b0;
        div_start = 1'b0;
        sqrt_start = 1'b0;
        case (state_reg)
            tsh_pkg::BS_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.cmd == tsh_pkg::CMD_END)
                    begin
                        q_pop = 1'b1;
                        state_next = (count_reg < 8'd3) ? tsh_pkg::BS_STATUS
                                                         : tsh_pkg::BS_MUL;
                    end
                    else if (out_free)
                    begin
                        q_pop = 1'b1;
                        out_load = 1'b1;
                    end
                end
            end
            tsh_pkg::BS_MUL:      state_next = tsh_pkg::BS_DIFF;
            tsh_pkg::BS_DIFF:
            begin
                div_start = 1'b1;
                state_next = tsh_pkg::BS_DIV_MEAN;
            end
            tsh_pkg::BS_DIV_MEAN:
            begin
                if (div_done)
                begin
                    sqrt_start = 1'b1;
                    state_next = tsh_pkg::BS_SQRT;
                end
            end
            tsh_pkg::BS_SQRT:
            begin
                if (sqrt_done)
                begin
                    div_start = 1'b1;
                    state_next = tsh_pkg::BS_DIV_SD;
                end
            end
            tsh_pkg::BS_DIV_SD:
            begin
                if (div_done)
                begin
                    state_next = tsh_pkg::BS_SUMMARY;
                end
            end
            tsh_pkg::BS_SUMMARY:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    state_next = tsh_pkg::BS_BINS;
                end
            end
            tsh_pkg::BS_BINS:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (bidx_reg == 5'(tsh_pkg::NUM_BINS - 1))
                    begin
                        state_next = tsh_pkg::BS_IDLE;
                    end
                end
            end
            tsh_pkg::BS_STATUS:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    state_next = tsh_pkg::BS_IDLE;
                end
            end
            default:              state_next = tsh_pkg::BS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsh_pkg::BS_IDLE;
            count_reg <= 8'd0;
            sum_reg <= 14'd0;
            sumsq_reg <= 21'd0;
            lo_reg <= 7'd100;
            hi_reg <= 7'd0;
            bidx_reg <= 5'd0;
            ovalid_reg <= 1'b0;
            is_mean_reg <= 1'b1;
            for (int i = 0; i < tsh_pkg::NUM_BINS; i++)
            begin
                bins_reg[i] <= 8'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            ovalid_reg <= out_load || (ovalid_reg && stall);
            if (div_done && state_reg == tsh_pkg::BS_DIV_MEAN)
            begin
                is_mean_reg <= 1'b0;
            end
            case (state_reg)
                tsh_pkg::BS_IDLE:
                begin
                    if (q_pop && q_item.cmd != tsh_pkg::CMD_END)
                    begin
                        if (q_item.cmd == tsh_pkg::CMD_ADD)
                        begin
                            count_reg <= count_reg + 8'd1;
                            sum_reg <= sum_reg + {7'd0, q_item.grade};
                            sumsq_reg <= sumsq_reg + {7'd0, g_sq};
                            if (q_item.grade < lo_reg)
                            begin
                                lo_reg <= q_item.grade;
                            end
                            if (q_item.grade > hi_reg)
                            begin
                                hi_reg <= q_item.grade;
                            end
                            bins_reg[q_item.bin] <= bins_reg[q_item.bin] + 8'd1;
                        end
                    end
                    is_mean_reg <= 1'b1;
                end
                tsh_pkg::BS_MUL:
                begin
                    bins_reg[tsh_pkg::grade_bin(lo_reg)] <=
                        bins_reg[tsh_pkg::grade_bin(lo_reg)] - 8'd1;
                end
                tsh_pkg::BS_DIFF:
                begin
                    bins_reg[tsh_pkg::grade_bin(hi_reg)] <=
                        bins_reg[tsh_pkg::grade_bin(hi_reg)] - 8'd1;
                end
                tsh_pkg::BS_SUMMARY:
                begin
                    if (out_free)
                    begin
                        bidx_reg <= 5'd0;
                    end
                end
                tsh_pkg::BS_BINS:
                begin
                    if (out_free)
                    begin
                        bidx_reg <= bidx_reg + 5'd1;
                        if (bidx_reg == 5'(tsh_pkg::NUM_BINS - 1))
                        begin
                            count_reg <= 8'd0;
                            sum_reg <= 14'd0;
                            sumsq_reg <= 21'd0;
                            lo_reg <= 7'd100;
                            hi_reg <= 7'd0;
                            for (int i = 0; i < tsh_pkg::NUM_BINS; i++)
                            begin
                                bins_reg[i] <= 8'd0;
                            end
                        end
                    end
                end
                tsh_pkg::BS_STATUS:
                begin
                    if (out_free)
                    begin
                        count_reg <= 8'd0;
                        sum_reg <= 14'd0;
                        sumsq_reg <= 21'd0;
                        lo_reg <= 7'd100;
                        hi_reg <= 7'd0;
                        for (int i = 0; i < tsh_pkg::NUM_BINS; i++)
                        begin
                            bins_reg[i] <= 8'd0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Datapath for the end computation.
    always_ff @(posedge clk)
    begin
        if (state_reg == tsh_pkg::BS_IDLE)
        begin
            m_reg <= count_reg - 8'd2;
            s_reg <= sum_reg - {7'd0, lo_reg} - {7'd0, hi_reg};
            q_reg <= sumsq_reg - 21'({7'd0, lo_reg} * {7'd0, lo_reg})
                               - 21'({7'd0, hi_reg} * {7'd0, hi_reg});
        end
        if (state_reg == tsh_pkg::BS_MUL)
        begin
            mq_reg <= 29'({21'd0, m_reg} * {8'd0, q_reg});
            ss_reg <= {14'd0, s_reg} * {14'd0, s_reg};
        end
        if (state_reg == tsh_pkg::BS_DIFF)
        begin
            d_reg <= (mq_reg > {1'b0, ss_reg}) ? mq_reg - {1'b0, ss_reg} : 29'd0;
        end
        if (div_done && state_reg == tsh_pkg::BS_DIV_MEAN)
        begin
            mean_reg <= div_quo[14:0];
        end
        if (div_done && state_reg == tsh_pkg::BS_DIV_SD)
        begin
            sd_reg <= div_quo[13:0];
        end
        if (out_free)
        begin
            kind_reg <= tsh_pkg::KIND_STATUS;
            status_reg <= q_item.status;
            rmin_reg <= 7'd0;
            rmax_reg <= 7'd0;
            omean_reg <= 15'd0;
            osd_reg <= 14'd0;
            obidx_reg <= 5'd0;
            obcnt_reg <= 8'd0;
            last_reg <= 1'b1;
            case (state_reg)
                tsh_pkg::BS_SUMMARY:
                begin
                    kind_reg <= tsh_pkg::KIND_SUMMARY;
                    status_reg <= tsh_pkg::ST_OK;
                    rmin_reg <= lo_reg;
                    rmax_reg <= hi_reg;
                    omean_reg <= mean_reg;
                    osd_reg <= sd_reg;
                    last_reg <= 1'b0;
                end
                tsh_pkg::BS_BINS:
                begin
                    kind_reg <= tsh_pkg::KIND_BIN;
                    status_reg <= tsh_pkg::ST_OK;
                    obidx_reg <= bidx_reg;
                    obcnt_reg <= bins_reg[bidx_reg];
                    last_reg <= (bidx_reg == 5'(tsh_pkg::NUM_BINS - 1));
                end
                tsh_pkg::BS_STATUS:
                begin
                    kind_reg <= tsh_pkg::KIND_SUMMARY;
                    status_reg <= tsh_pkg::ST_TOO_FEW;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign valid = ovalid_reg;
    assign kind = kind_reg;
    assign status = status_reg;
    assign removed_min = rmin_reg;
    assign removed_max = rmax_reg;
    assign mean_value = omean_reg;
    assign std_dev = osd_reg;
    assign bin_index = obidx_reg;
    assign bin_count = obcnt_reg;
    assign last = last_reg;
endmodule

@@ rtl/trimmed_stats_histogram_unit.sv @@
// Top level of the trimmed grade statistics and histogram unit.
// Grades enter on the input channel and each one gives a status transfer on the output
// channel; a sample is taken every cycle as long as results are drained and no end item
// is in progress. An end item drops one minimum and one maximum, then gives a summary
// (trimmed mean in unsigned Q7.8 and population standard deviation in unsigned Q6.8,
// truncated) followed by 21 bin transfers, or a single too-few summary when fewer than
// three samples were kept; the unit then clears. After an end item is accepted it passes
// through the command queue, the setup states BS_MUL and BS_DIFF, a bit-serial divide of
// the mean, a bit-serial square root, a second divide on the same divider and the loading
// of the summary; the bin walk then follows, one bin transfer after another.
// A two-entry command queue separates the classifying front end from the accumulating
// back end.
module trimmed_stats_histogram_unit #(
    parameter int MAX_SAMPLES = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [7:0]  grade,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [1:0]  status,
    output logic [6:0]  removed_min,
    output logic [6:0]  removed_max,
    output logic [14:0] mean_value,
    output logic [13:0] std_dev,
    output logic [4:0]  bin_index,
    output logic [7:0]  bin_count,
    output logic        last
);
    logic                 q_valid, q_pop;
    tsh_pkg::front_item_t q_item;

    tsh_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid   (in_valid),
        .stall   (in_stall),
        .action  (action),
        .grade   (grade),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_item  (q_item)
    );

    tsh_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_item      (q_item),
        .valid       (out_valid),
        .stall       (out_stall),
        .kind        (kind),
        .status      (status),
        .removed_min (removed_min),
        .removed_max (removed_max),
        .mean_value  (mean_value),
        .std_dev     (std_dev),
        .bin_index   (bin_index),
        .bin_count   (bin_count),
        .last        (last)
    );
endmodule

@@ tb/tsh_checker.sv @@
// Checker that predicts and compares the result transfers of the statistics unit.
`timescale 1ns / 100ps
module tsh_checker #(
    parameter int MAX_SAMPLES = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        action,
    input  logic [7:0]  grade,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  kind,
    input  logic [1:0]  status,
    input  logic [6:0]  removed_min,
    input  logic [6:0]  removed_max,
    input  logic [14:0] mean_value,
    input  logic [13:0] std_dev,
    input  logic [4:0]  bin_index,
    input  logic [7:0]  bin_count,
    input  logic        last,
    output int          fail_count,
    output int          pending
);

    typedef struct packed
    {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [6:0]  rmin;
        logic [6:0]  rmax;
        logic [14:0] mean;
        logic [13:0] sd;
        logic [4:0]  bidx;
        logic [7:0]  bcnt;
        logic        last;
    } grade_result_t;

    grade_result_t expected_results[$];

    int unsigned n_kept;
    int unsigned sum_kept;
    int unsigned sumsq_kept;
    int unsigned lowest;
    int unsigned highest;
    int unsigned hist[tsh_pkg::NUM_BINS];

    function automatic grade_result_t blank_result();
        grade_result_t r;
        r = '0;
        return r;
    endfunction

    task automatic clear_stats();
        n_kept = 0;
        sum_kept = 0;
        sumsq_kept = 0;
        lowest = tsh_pkg::GRADE_MAX;
        highest = 0;
        for (int k = 0; k < tsh_pkg::NUM_BINS; k++)
            hist[k] = 0;
    endtask

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x)
                root = trial;
        end
        return root;
    endfunction

    task automatic predict_grade(input logic act, input logic [7:0] g);
        grade_result_t r;
        longint unsigned m, s, q, mq, ss, d;
        r = blank_result();
        r.last = 1'b1;
        if (!act)
        begin
            r.kind = tsh_pkg::KIND_STATUS;
            if (g > tsh_pkg::GRADE_MAX)
                r.status = tsh_pkg::ST_RANGE;
            else if (n_kept >= MAX_SAMPLES)
                r.status = tsh_pkg::ST_FULL;
            else
            begin
                r.status = tsh_pkg::ST_OK;
                n_kept++;
                sum_kept += 32'(g);
                sumsq_kept += 32'(g) * 32'(g);
                if (32'(g) < lowest) lowest = 32'(g);
                if (32'(g) > highest) highest = 32'(g);
                hist[g / 5]++;
            end
            expected_results.push_back(r);
        end
        else if (n_kept < 3)
        begin
            r.kind = tsh_pkg::KIND_SUMMARY;
            r.status = tsh_pkg::ST_TOO_FEW;
            expected_results.push_back(r);
            clear_stats();
        end
        else
        begin
            m = 64'(n_kept) - 64'd2;
            s = 64'(sum_kept) - 64'(lowest) - 64'(highest);
            q = 64'(sumsq_kept) - 64'(lowest) * 64'(lowest) - 64'(highest) * 64'(highest);
            mq = m * q;
            ss = s * s;
            d = (mq > ss) ? mq - ss : 64'd0;
            hist[lowest / 5]--;
            hist[highest / 5]--;
            r.kind = tsh_pkg::KIND_SUMMARY;
            r.status = tsh_pkg::ST_OK;
            r.rmin = 7'(lowest);
            r.rmax = 7'(highest);
            r.mean = 15'((s * 64'd256) / m);
            r.sd = 14'(floor_sqrt(d * 64'd65536) / m);
            r.last = 1'b0;
            expected_results.push_back(r);
            for (int k = 0; k < tsh_pkg::NUM_BINS; k++)
            begin
                r = blank_result();
                r.kind = tsh_pkg::KIND_BIN;
                r.bidx = 5'(k);
                r.bcnt = 8'(hist[k]);
                r.last = (k == tsh_pkg::NUM_BINS - 1);
                expected_results.push_back(r);
            end
            clear_stats();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        grade_result_t got;
        grade_result_t want;
        if (!rst_n)
        begin
            clear_stats();
            expected_results.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_grade(action, grade);
            if (out_valid && !out_stall)
            begin
                got = '{kind, status, removed_min, removed_max, mean_value, std_dev,
                        bin_index, bin_count, last};
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transfer: %p", got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result mismatch: expected %p, got %p", want, got);
                    end
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

@@ tb/tb.sv @@
// Top of the testbench: drives grades and end items and gives the verdict.
`timescale 1ns / 100ps
module tb;

    localparam int MAX_SAMPLES = 128;
    localparam int DRAIN_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic ACT_ADD = 1'b0;
    localparam logic ACT_END = 1'b1;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        action;
    logic [7:0]  grade;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [6:0]  removed_min;
    logic [6:0]  removed_max;
    logic [14:0] mean_value;
    logic [13:0] std_dev;
    logic [4:0]  bin_index;
    logic [7:0]  bin_count;
    logic        last;
    int          fail_count;
    int          pending;

    // When set, both sides stop idling so that back-to-back transfers occur.
    logic        busy_stretch;
    int          idle_cycles;

    trimmed_stats_histogram_unit #(.MAX_SAMPLES(MAX_SAMPLES)) dut (.*);

    tsh_checker #(.MAX_SAMPLES(MAX_SAMPLES)) chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver stalls at random about 22 percent of the time, except in busy stretches.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= !busy_stretch && ($urandom_range(99, 0) < 22);
    end

    // The watchdog counts cycles without any transfer on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Presents one item and holds it until it is accepted. A random gap may come first.
    task automatic send_item(input logic act, input logic [7:0] g);
        while (!busy_stretch && ($urandom_range(99, 0) < 22))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        grade <= g;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_grade(input logic [7:0] g);
        send_item(ACT_ADD, g);
    endtask

    task automatic send_end();
        send_item(ACT_END, 8'($urandom_range(255, 0)));
    endtask

    // Mostly valid grades, with some beyond the accepted range.
    function automatic logic [7:0] pick_grade();
        if ($urandom_range(99, 0) < 12)
            return 8'($urandom_range(255, 101));
        return 8'($urandom_range(tsh_pkg::GRADE_MAX, 0));
    endfunction

    // Waits until every expected result has arrived, then lets the block settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int set_size;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_ADD;
        grade = 8'd0;
        busy_stretch = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty end, too-few ends, out-of-range grades, grade extremes.
        send_end();
        send_grade(8'd100);
        send_grade(8'd101);
        send_grade(8'd255);
        send_end();
        send_grade(8'd0);
        send_grade(8'd100);
        send_grade(8'd100);
        send_grade(8'd4);
        send_grade(8'd5);
        send_grade(8'd99);
        send_grade(8'd0);
        send_end();
        // Identical grades give a zero deviation.
        send_grade(8'd50);
        send_grade(8'd50);
        send_grade(8'd50);
        send_end();
        // The sender holds off until everything has come back.
        drain_results();

        // Fill the store past capacity to reach the full status, in a busy stretch.
        busy_stretch = 1'b1;
        for (int i = 0; i < MAX_SAMPLES + 3; i++)
            send_grade(8'($urandom_range(tsh_pkg::GRADE_MAX, 0)));
        busy_stretch = 1'b0;
        send_end();

        // Random data sets, mostly small, some larger; every grade bit is exercised.
        for (int n = 0; n < 170; n += set_size + 1)
        begin
            set_size = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 0)
                                                   : $urandom_range(12, 0);
            for (int i = 0; i < set_size; i++)
                send_grade(pick_grade());
            send_end();
        end

        drain_results();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
